[src/pwpf_pkg.sv]
// Shared constants, codes and command/status types of the polygon wall point filter.
`default_nettype none
package pwpf_pkg;

  // Vertex storage geometry.
  localparam int MaxVertices = 64;
  localparam int AddrW       = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);

  // Field widths of the transactions and registers.
  localparam int CoordW  = 16;
  localparam int IndexW  = 6;
  localparam int VcountW = 7;
  localparam int MarginW = 16;
  localparam int VertexW = 2 * CoordW;

  // Configuration port geometry.
  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  // Operation codes of an input transaction.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_WALL_MARGIN  = 1'b1;

  // What the controller asks the vertex memory read port to do in a cycle.
  typedef enum logic [1:0] {
    ISS_NONE  = 2'd0,
    ISS_LOAD  = 2'd1,
    ISS_EDGE  = 2'd2,
    ISS_CLOSE = 2'd3
  } issue_e;

  typedef struct packed {
    logic             wr_en;
    logic             latch;
    issue_e           issue;
    logic [AddrW-1:0] rd_addr;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

endpackage
`default_nettype wire

[src/pwpf_if.sv]
// Valid/ready channel interfaces for request and result transactions.
`default_nettype none
interface pwpf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [pwpf_pkg::IndexW-1:0]      vertex_index;
  logic signed [pwpf_pkg::CoordW-1:0] coord_x;
  logic signed [pwpf_pkg::CoordW-1:0] coord_y;

  modport source (output valid, op, vertex_index, coord_x, coord_y, input ready);
  modport sink (input valid, op, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pwpf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pwpf_pkg::CoordW-1:0] point_x;
  logic signed [pwpf_pkg::CoordW-1:0] point_y;
  logic                               keep;

  modport source (output valid, point_x, point_y, keep, input ready);
  modport sink (input valid, point_x, point_y, keep, output ready);
endinterface
`default_nettype wire

[src/pwpf_regs.sv]
// Configuration register file with an APB-style write and read port.
`default_nettype none
module pwpf_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pwpf_pkg::PaddrW-1:0]    paddr,
  input  wire logic [pwpf_pkg::PdataW-1:0]    pwdata,
  output logic      [pwpf_pkg::PdataW-1:0]    prdata,
  output logic                                pready,
  output logic      [pwpf_pkg::VcountW-1:0]   vertex_count_o,
  output logic      [pwpf_pkg::MarginW-1:0]   wall_margin_o
);

  logic [pwpf_pkg::VcountW-1:0] vertex_count_q;
  logic [pwpf_pkg::MarginW-1:0] wall_margin_q;
  logic                         wr_en;
  logic                         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
      wall_margin_q  <= pwpf_pkg::MarginW'(150);
    end else if (wr_en) begin
      unique case (reg_idx)
        pwpf_pkg::REG_VERTEX_COUNT: vertex_count_q <= pwdata[pwpf_pkg::VcountW-1:0];
        pwpf_pkg::REG_WALL_MARGIN:  wall_margin_q  <= pwdata[pwpf_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pwpf_pkg::REG_VERTEX_COUNT: prdata = pwpf_pkg::PdataW'(vertex_count_q);
      pwpf_pkg::REG_WALL_MARGIN:  prdata = pwpf_pkg::PdataW'(wall_margin_q);
      default:                    prdata = '0;
    endcase
  end

  assign vertex_count_o = vertex_count_q;
  assign wall_margin_o  = wall_margin_q;

endmodule
`default_nettype wire

[src/pwpf_dp.sv]
// Datapath: vertex memory, five-stage edge distance pipeline and result register.
`default_nettype none
module pwpf_dp (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire pwpf_pkg::ctrl_cmd_t                  cmd_i,
  output pwpf_pkg::dp_status_t                      status_o,
  input  wire logic [pwpf_pkg::IndexW-1:0]          vertex_index_i,
  input  wire logic signed [pwpf_pkg::CoordW-1:0]   coord_x_i,
  input  wire logic signed [pwpf_pkg::CoordW-1:0]   coord_y_i,
  input  wire logic [pwpf_pkg::MarginW-1:0]         wall_margin_i,
  output logic signed [pwpf_pkg::CoordW-1:0]        point_x_o,
  output logic signed [pwpf_pkg::CoordW-1:0]        point_y_o,
  output logic                                      keep_o
);

  localparam int DW = pwpf_pkg::CoordW + 1;  // coordinate differences
  localparam int PW = 2 * DW;                // their products
  localparam int SW = PW + 1;                // sums of two products
  localparam int HW = DW;                    // half of the cross magnitude

  // Vertex memory, x in the low half and y in the high half.
  logic [pwpf_pkg::VertexW-1:0] mem_q [pwpf_pkg::MaxVertices];
  logic [pwpf_pkg::VertexW-1:0] rdata_q;
  logic [pwpf_pkg::VertexW-1:0] first_q, a_q, b_vtx;
  pwpf_pkg::issue_e             tag_q;

  // Point under test and the squared margin.
  logic signed [pwpf_pkg::CoordW-1:0] px_q, py_q;
  logic [2*pwpf_pkg::MarginW-1:0]     m2_q;

  // Stage registers.
  logic                 v1_q, v2_q, v3_q, v4_q;
  logic signed [DW-1:0] dx_q, dy_q, qx_q, qy_q, ex_q, ey_q;
  logic signed [DW-1:0] ax, ay, bx, by, pxe, pye;
  logic signed [PW-1:0] p_dxdx_q, p_dydy_q, p_qxdx_q, p_qydy_q, p_qxdy_q, p_qydx_q;
  logic signed [PW-1:0] p_qxqx_q, p_qyqy_q, p_exex_q, p_eyey_q;
  logic signed [SW-1:0] len_w, s_w, da_w, db_w, cross_w, cneg_w;
  logic [SW-3:0]        len2_q, da_q, db_q;
  logic signed [SW-1:0] s_q;
  logic [SW-2:0]        cabs_q;
  logic [HW-1:0]        ch, cl;
  logic [SW-2-HW:0]     lh;
  logic [HW-2:0]        ll;
  logic                 lz_q, sle0_q, sge_q, na_q, nb_q;
  logic [PW-1:0]        hh_q, hl_q, lo_q;
  logic [2*pwpf_pkg::MarginW+SW-2-HW:0] rh_q;
  logic [2*pwpf_pkg::MarginW+HW-2:0]    rl_q;
  logic [2*SW-3:0]      c2_w, r_w;
  logic                 near_w, near_q;
  logic                 wr_ok;

  // Vertex memory: one write port, one registered read port.
  assign wr_ok = int'(vertex_index_i) < pwpf_pkg::MaxVertices;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem_q[pwpf_pkg::AddrW'(vertex_index_i)] <= {coord_y_i, coord_x_i};
    end
    if (cmd_i.issue == pwpf_pkg::ISS_LOAD || cmd_i.issue == pwpf_pkg::ISS_EDGE) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= pwpf_pkg::ISS_NONE;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
    end else begin
      tag_q <= cmd_i.issue;
      v1_q  <= (tag_q == pwpf_pkg::ISS_EDGE) || (tag_q == pwpf_pkg::ISS_CLOSE);
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
    end
  end

  assign status_o.busy = (tag_q != pwpf_pkg::ISS_NONE) | v1_q | v2_q | v3_q | v4_q;

  // The closing edge runs from the last vertex back to vertex zero.
  assign b_vtx = (tag_q == pwpf_pkg::ISS_CLOSE) ? first_q : rdata_q;
  assign ax    = DW'(signed'(a_q[pwpf_pkg::CoordW-1:0]));
  assign ay    = DW'(signed'(a_q[pwpf_pkg::VertexW-1:pwpf_pkg::CoordW]));
  assign bx    = DW'(signed'(b_vtx[pwpf_pkg::CoordW-1:0]));
  assign by    = DW'(signed'(b_vtx[pwpf_pkg::VertexW-1:pwpf_pkg::CoordW]));
  assign pxe   = DW'(px_q);
  assign pye   = DW'(py_q);

  // Stage 1: differences, and the running start vertex of the next edge.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
      m2_q <= wall_margin_i * wall_margin_i;
    end
    if (tag_q == pwpf_pkg::ISS_LOAD) begin
      first_q <= rdata_q;
    end
    if (tag_q != pwpf_pkg::ISS_NONE) begin
      a_q <= b_vtx;
    end
    dx_q <= bx - ax;
    dy_q <= by - ay;
    qx_q <= pxe - ax;
    qy_q <= pye - ay;
    ex_q <= pxe - bx;
    ey_q <= pye - by;
  end

  // Stage 2: all narrow products.
  always_ff @(posedge clk_i) begin
    p_dxdx_q <= dx_q * dx_q;
    p_dydy_q <= dy_q * dy_q;
    p_qxdx_q <= qx_q * dx_q;
    p_qydy_q <= qy_q * dy_q;
    p_qxdy_q <= qx_q * dy_q;
    p_qydx_q <= qy_q * dx_q;
    p_qxqx_q <= qx_q * qx_q;
    p_qyqy_q <= qy_q * qy_q;
    p_exex_q <= ex_q * ex_q;
    p_eyey_q <= ey_q * ey_q;
  end

  // Stage 3: squared length, projection, cross product and end distances.
  assign len_w   = SW'(p_dxdx_q) + SW'(p_dydy_q);
  assign s_w     = SW'(p_qxdx_q) + SW'(p_qydy_q);
  assign da_w    = SW'(p_qxqx_q) + SW'(p_qyqy_q);
  assign db_w    = SW'(p_exex_q) + SW'(p_eyey_q);
  assign cross_w = SW'(p_qxdy_q) - SW'(p_qydx_q);
  assign cneg_w  = -cross_w;

  always_ff @(posedge clk_i) begin
    len2_q <= len_w[SW-3:0];
    s_q    <= s_w;
    da_q   <= da_w[SW-3:0];
    db_q   <= db_w[SW-3:0];
    cabs_q <= cross_w[SW-1] ? cneg_w[SW-2:0] : cross_w[SW-2:0];
  end

  // Stage 4: region flags and split partial products of the interior test.
  assign ch = cabs_q[SW-2:HW];
  assign cl = cabs_q[HW-1:0];
  assign lh = len2_q[SW-3:HW-1];
  assign ll = len2_q[HW-2:0];

  always_ff @(posedge clk_i) begin
    lz_q   <= (len2_q == '0);
    sle0_q <= (s_q <= SW'(0));
    sge_q  <= (s_q >= signed'({2'b00, len2_q}));
    na_q   <= ({1'b0, da_q} < (SW-1)'(m2_q));
    nb_q   <= ({1'b0, db_q} < (SW-1)'(m2_q));
    hh_q   <= PW'(ch) * PW'(ch);
    hl_q   <= PW'(ch) * PW'(cl);
    lo_q   <= PW'(cl) * PW'(cl);
    rh_q   <= m2_q * lh;
    rl_q   <= m2_q * ll;
  end

  // Stage 5: reassemble the wide products, compare and accumulate.
  assign c2_w = ((2*SW-2)'(hh_q) << (2*HW)) + ((2*SW-2)'(hl_q) << (HW+1))
              + (2*SW-2)'(lo_q);
  assign r_w  = ((2*SW-2)'(rh_q) << (HW-1)) + (2*SW-2)'(rl_q);

  always_comb begin
    priority if (lz_q) begin
      near_w = 1'b0;
    end else if (sle0_q) begin
      near_w = na_q;
    end else if (sge_q) begin
      near_w = nb_q;
    end else begin
      near_w = (c2_w < r_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= 1'b0;
    end else if (cmd_i.latch) begin
      near_q <= 1'b0;
    end else if (v4_q && near_w) begin
      near_q <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      point_x_o <= px_q;
      point_y_o <= py_q;
      keep_o    <= ~near_q;
    end
  end

endmodule
`default_nettype wire

[src/pwpf_ctrl.sv]
// Controller: accepts transactions, sequences the edge walk and hands off results.
`default_nettype none
module pwpf_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_op_i,
  output logic                               in_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire logic [pwpf_pkg::VcountW-1:0]  vertex_count_i,
  input  wire pwpf_pkg::dp_status_t          status_i,
  output pwpf_pkg::ctrl_cmd_t                cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FIRST = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [pwpf_pkg::CntW-1:0]   idx_q, idx_d;
  logic [pwpf_pkg::CntW-1:0]   cnt_sat;
  logic                        out_valid_q, out_valid_d;
  logic                        in_acc;

  assign cnt_sat = (int'(vertex_count_i) > pwpf_pkg::MaxVertices)
                 ? pwpf_pkg::CntW'(pwpf_pkg::MaxVertices)
                 : pwpf_pkg::CntW'(vertex_count_i);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.issue = pwpf_pkg::ISS_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op_i == pwpf_pkg::OP_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.latch = 1'b1;
            state_d     = (cnt_sat == '0) ? ST_DONE : ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        cmd_o.issue   = pwpf_pkg::ISS_LOAD;
        cmd_o.rd_addr = '0;
        idx_d         = pwpf_pkg::CntW'(1);
        state_d       = ST_WALK;
      end
      ST_WALK: begin
        if (idx_q < cnt_sat) begin
          cmd_o.issue   = pwpf_pkg::ISS_EDGE;
          cmd_o.rd_addr = idx_q[pwpf_pkg::AddrW-1:0];
          idx_d         = idx_q + pwpf_pkg::CntW'(1);
        end else begin
          cmd_o.issue = pwpf_pkg::ISS_CLOSE;
          state_d     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

[src/polygon_wall_point_filter.sv]
// Top level of the polygon wall point filter: register file, controller and datapath.
// A vertex write transaction is taken while idle and leaves the block ready for the next one.
// A point test with N vertices (N saturated to 64) shows a valid result after one read per
// edge and a five-stage pipeline drain; with no vertices it skips the edge walk.
// One test is in flight at a time, so no new transaction is taken until its result is loaded.
// rst_ni clears control state and the registers; the vertex memory is not cleared.
`default_nettype none
module polygon_wall_point_filter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  pwpf_in_if.sink                             req_i,
  pwpf_out_if.source                          rsp_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pwpf_pkg::PaddrW-1:0]    paddr,
  input  wire logic [pwpf_pkg::PdataW-1:0]    pwdata,
  output logic      [pwpf_pkg::PdataW-1:0]    prdata,
  output logic                                pready
);

  // The register file supplies the live vertex count and margin. The user must
  // change them only while no transaction is in progress; the block does not
  // enforce this, and the controller and datapath sample them during a test.
  logic [pwpf_pkg::VcountW-1:0] vertex_count;
  logic [pwpf_pkg::MarginW-1:0] wall_margin;
  pwpf_pkg::ctrl_cmd_t          cmd;
  pwpf_pkg::dp_status_t         status;

  pwpf_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .vertex_count_o (vertex_count),
    .wall_margin_o  (wall_margin)
  );

  // The controller takes one transaction at a time. A write goes straight
  // into the vertex memory. A test latches the point, then issues one vertex
  // read per cycle: vertex zero first, then each following vertex forms an
  // edge with the one before it, and a final closing edge returns to vertex
  // zero. The result waits in an output register, so a new transaction can be
  // accepted while the previous result has not yet been taken.
  pwpf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_op_i        (req_i.op),
    .in_ready_o     (req_i.ready),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .vertex_count_i (vertex_count),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  // The datapath evaluates one edge per cycle with exact integer math: end
  // point distances where the projection falls outside the edge, otherwise
  // the squared cross product against margin squared times the squared
  // length. The wide products are split into 17-bit partial products. A
  // zero-length edge never counts as near.
  pwpf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .vertex_index_i (req_i.vertex_index),
    .coord_x_i      (req_i.coord_x),
    .coord_y_i      (req_i.coord_y),
    .wall_margin_i  (wall_margin),
    .point_x_o      (rsp_o.point_x),
    .point_y_o      (rsp_o.point_y),
    .keep_o         (rsp_o.keep)
  );

endmodule
`default_nettype wire

[src/pwpf_checker.sv]
// Port-level assertions of the polygon wall point filter and their bind.
`default_nettype none
module pwpf_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_ready_i,
  input  wire logic                                in_op_i,
  input  wire logic                                out_valid_i,
  input  wire logic                                out_ready_i,
  input  wire logic signed [pwpf_pkg::CoordW-1:0]  out_point_x_i,
  input  wire logic signed [pwpf_pkg::CoordW-1:0]  out_point_y_i,
  input  wire logic                                out_keep_i
);

  // A result held back by the sink stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_point_x_i) && $stable(out_point_y_i) && $stable(out_keep_i))
    else $error("result payload changed while stalled");

  // A point test occupies the block, so it is not ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == pwpf_pkg::OP_TEST) |=> !in_ready_i)
    else $error("ready after a test transaction");

  // A vertex write completes at once and the block stays ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == pwpf_pkg::OP_WRITE) |=> in_ready_i)
    else $error("not ready after a write transaction");

  // A new result only appears at the end of a test, when input was blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a test in progress");

endmodule

bind polygon_wall_point_filter pwpf_checker u_pwpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_op_i       (req_i.op),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_point_x_i (rsp_o.point_x),
  .out_point_y_i (rsp_o.point_y),
  .out_keep_i    (rsp_o.keep)
);
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the polygon wall point filter: directed rows, then random rooms.
module tb_top;
  import pwpf_pkg::*;

  // One request transaction as the bench builds it.
  typedef struct {
    logic                     op;
    logic [IndexW-1:0]        slot;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } wall_req_t;

  // One result transaction: the point passed through and its verdict.
  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     keep;
  } filtered_point_t;

  typedef enum {STEP_ITEM, STEP_REG} step_kind_e;

  // A row of the directed part is either a transaction or a register write.
  typedef struct {
    step_kind_e        kind;
    wall_req_t         req;
    logic              reg_sel;
    logic [PdataW-1:0] value;
    int                keep_known;
  } step_t;

  // A directed row with this verdict is checked against the bench's own geometry.
  localparam int Derived = -1;
  // A test walks at most MaxVertices edges plus a short pipeline, so this
  // many quiet cycles guarantee the block has settled.
  localparam int DrainCycles = MaxVertices + 16;
  localparam int TotalItems  = 725;
  localparam int CalmAfter   = 640;
  localparam int BacklogHold = 300;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  pwpf_in_if  req_if ();
  pwpf_out_if rsp_if ();

  polygon_wall_point_filter dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk_i = ~clk_i;

  // The bench's own view of the block: the room outline, the number of
  // vertices in use and the clearance that a point must keep from every wall.
  logic signed [CoordW-1:0] room_x [MaxVertices];
  logic signed [CoordW-1:0] room_y [MaxVertices];
  logic [VcountW-1:0]       room_size;
  logic [MarginW-1:0]       clear_mm;

  filtered_point_t awaited_points[$];
  step_t           directed[$];

  int items_taken  = 0;
  int points_seen  = 0;
  int errors       = 0;
  bit calm         = 1'b0;
  bit gaps_on      = 1'b1;
  bit backlog_done = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  // Exact test of whether point P lies closer than the clearance to segment
  // A->B. The perpendicular case compares squared cross product against
  // m2 * |d|^2 in 128 bits, so no division and no rounding is involved.
  function automatic bit edge_is_close(longint px, longint py, longint ax, longint ay,
                                       longint bx, longint by, longint m2);
    longint     dx, dy, qx, qy, len2, s, ex, ey, cr;
    logic [127:0] cr2, lim;
    dx   = bx - ax;
    dy   = by - ay;
    qx   = px - ax;
    qy   = py - ay;
    len2 = dx * dx + dy * dy;
    s    = qx * dx + qy * dy;
    // A wall of zero length never rejects anything.
    if (len2 == 0) return 1'b0;
    if (s <= 0) return (qx * qx + qy * qy) < m2;
    if (s >= len2) begin
      ex = px - bx;
      ey = py - by;
      return (ex * ex + ey * ey) < m2;
    end
    cr = qx * dy - qy * dx;
    if (cr < 0) cr = -cr;
    cr2 = 128'(cr) * 128'(cr);
    lim = 128'(m2) * 128'(len2);
    return cr2 < lim;
  endfunction

  // Verdict for one lidar point against the closed outline. A count above
  // the storage size is clamped, and an empty room keeps every point.
  function automatic bit point_clear_of_walls(logic signed [CoordW-1:0] px,
                                              logic signed [CoordW-1:0] py);
    int     n, j;
    longint m2;
    n  = (room_size > MaxVertices) ? MaxVertices : room_size;
    m2 = longint'(clear_mm) * longint'(clear_mm);
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      if (edge_is_close(px, py, room_x[i], room_y[i], room_x[j], room_y[j], m2)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [CoordW-1:0] to_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return CoordW'(v);
  endfunction

  function automatic longint jitter(int reach);
    return longint'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic void add_item(logic op, int slot, int x, int y, int keep_known);
    step_t st;
    st.kind       = STEP_ITEM;
    st.req.op     = op;
    st.req.slot   = IndexW'(slot);
    st.req.x      = CoordW'(x);
    st.req.y      = CoordW'(y);
    st.reg_sel    = REG_VERTEX_COUNT;
    st.value      = '0;
    st.keep_known = keep_known;
    directed.insert(directed.size(), st);
  endfunction

  function automatic void add_reg(logic sel, int value);
    step_t st;
    st.kind       = STEP_REG;
    st.req.op     = OP_WRITE;
    st.req.slot   = '0;
    st.req.x      = '0;
    st.req.y      = '0;
    st.reg_sel    = sel;
    st.value      = PdataW'(value);
    st.keep_known = Derived;
    directed.insert(directed.size(), st);
  endfunction

  // Register writes happen only with the block idle: the request side is
  // parked, every awaited point has come back, and a stray vertex write has
  // had time to finish. Setup cycle, then access cycle.
  task automatic write_reg(input logic sel, input logic [PdataW-1:0] value);
    req_if.valid <= 1'b0;
    while (awaited_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'(sel) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_VERTEX_COUNT) room_size = value[VcountW-1:0];
    else clear_mm = value[MarginW-1:0];
  endtask

  // Offers one request transaction and, once it is taken, folds it into the
  // bench's room state or queues the verdict the block owes for it. Valid is
  // left high after acceptance so back-to-back transactions need no toggle.
  task automatic push_req(input wall_req_t rq, input int keep_known);
    filtered_point_t fp;
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.op           <= rq.op;
    req_if.vertex_index <= rq.slot;
    req_if.coord_x      <= rq.x;
    req_if.coord_y      <= rq.y;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_taken++;
    if (items_taken >= CalmAfter) calm = 1'b1;
    if (rq.op == OP_WRITE) begin
      room_x[rq.slot] = rq.x;
      room_y[rq.slot] = rq.y;
    end else begin
      fp.x    = rq.x;
      fp.y    = rq.y;
      fp.keep = (keep_known == Derived) ? point_clear_of_walls(rq.x, rq.y) : keep_known[0];
      awaited_points.insert(awaited_points.size(), fp);
    end
  endtask

  initial begin : stimulus
    wall_req_t rq;
    int        size, nv, margin, span, ntests, mode, a, b, t, reach, phase;
    // Start from a known level on every input of the block.
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_if.valid        <= 1'b0;
    req_if.op           <= OP_WRITE;
    req_if.vertex_index <= '0;
    req_if.coord_x      <= '0;
    req_if.coord_y      <= '0;
    room_size = '0;
    clear_mm  = MarginW'(150);

    // Empty room after reset: every point passes, the coordinate extremes too.
    add_item(OP_TEST, 0, 0, 0, 1);
    add_item(OP_TEST, 63, -32768, 32767, 1);
    add_item(OP_TEST, 21, 32767, -32768, 1);
    // A 2 m square with the reset clearance of 150 mm.
    add_item(OP_WRITE, 0, -1000, -1000, Derived);
    add_item(OP_WRITE, 1, 1000, -1000, Derived);
    add_item(OP_WRITE, 2, 1000, 1000, Derived);
    add_item(OP_WRITE, 3, -1000, 1000, Derived);
    add_reg(REG_VERTEX_COUNT, 4);
    add_item(OP_TEST, 0, 0, 0, 1);
    add_item(OP_TEST, 0, 0, -950, 0);
    // Exactly at the clearance is not closer than it, so the point stays.
    add_item(OP_TEST, 0, 0, -850, 1);
    add_item(OP_TEST, 0, -1100, -1100, Derived);
    add_item(OP_TEST, 0, 1100, 0, Derived);
    // A repeated vertex gives a wall of zero length.
    add_item(OP_WRITE, 4, -1000, 1000, Derived);
    add_reg(REG_VERTEX_COUNT, 5);
    add_item(OP_TEST, 0, -1000, 0, Derived);
    add_item(OP_TEST, 0, -1200, 1000, Derived);
    // A single vertex closes on itself and never rejects, even on top of it.
    add_reg(REG_VERTEX_COUNT, 1);
    add_item(OP_TEST, 0, -1000, -1000, 1);
    // Two vertices: the same wall walked both ways.
    add_reg(REG_VERTEX_COUNT, 2);
    add_item(OP_TEST, 0, 0, -1000, Derived);
    // Zero clearance keeps even a point lying on a wall.
    add_reg(REG_VERTEX_COUNT, 4);
    add_reg(REG_WALL_MARGIN, 0);
    add_item(OP_TEST, 0, 0, -1000, 1);
    // Full-range room with the widest clearance stresses the 128-bit compare.
    add_item(OP_WRITE, 0, -32768, -32768, Derived);
    add_item(OP_WRITE, 1, 32767, -32768, Derived);
    add_item(OP_WRITE, 2, 32767, 32767, Derived);
    add_item(OP_WRITE, 3, -32768, 32767, Derived);
    add_reg(REG_WALL_MARGIN, 65535);
    add_item(OP_TEST, 0, 0, 0, 0);
    add_item(OP_TEST, 0, 32767, 32767, Derived);
    add_item(OP_TEST, 0, -32768, 0, Derived);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) begin
      if (directed[k].kind == STEP_REG) write_reg(directed[k].reg_sel, directed[k].value);
      else push_req(directed[k].req, directed[k].keep_known);
    end

    // Random rooms. Each phase sets a vertex count and a clearance, writes
    // the outline, then fires points at it: some anywhere, others near a wall
    // or a corner so that verdicts fall on both sides. Now and then a stray
    // vertex write lands in the middle and bends the room.
    phase = 0;
    while (items_taken < TotalItems) begin
      mode = $urandom_range(0, 15);
      if (phase == 0) size = 127;
      else if (phase == 1 || mode == 0) size = 0;
      else if (mode == 1) size = 1;
      else if (mode == 2) size = 2;
      else if (mode == 3) size = $urandom_range(64, 127);
      else size = $urandom_range(3, 12);
      mode = $urandom_range(0, 7);
      if (mode == 0) margin = 0;
      else if (mode == 1) margin = 65535;
      else if (mode == 2) margin = $urandom_range(0, 65535);
      else margin = $urandom_range(20, 1500);
      mode = $urandom_range(0, 2);
      span = (mode == 0) ? 2000 : (mode == 1) ? 8000 : 32767;
      write_reg(REG_VERTEX_COUNT, PdataW'(size));
      write_reg(REG_WALL_MARGIN, PdataW'(margin));
      gaps_on = ($urandom_range(0, 2) != 0);
      nv = (size > MaxVertices) ? MaxVertices : size;

      for (int k = 0; k < nv; k++) begin
        rq.op   = OP_WRITE;
        rq.slot = IndexW'(k);
        if (k > 0 && $urandom_range(0, 9) == 0) begin
          rq.x = room_x[k - 1];
          rq.y = room_y[k - 1];
        end else if ($urandom_range(0, 7) == 0) begin
          rq.x = CoordW'($urandom);
          rq.y = CoordW'($urandom);
        end else begin
          rq.x = to_coord(jitter(span));
          rq.y = to_coord(jitter(span));
        end
        push_req(rq, Derived);
      end

      ntests = (nv > 16) ? $urandom_range(4, 8) : $urandom_range(4, 14);
      reach  = clear_mm + 40;
      repeat (ntests) begin
        if ($urandom_range(0, 7) == 0) begin
          rq.op   = OP_WRITE;
          rq.slot = IndexW'($urandom);
          rq.x    = to_coord(jitter(span));
          rq.y    = to_coord(jitter(span));
          push_req(rq, Derived);
        end
        rq.op   = OP_TEST;
        rq.slot = IndexW'($urandom);
        mode    = $urandom_range(0, 3);
        if (nv == 0 || mode == 0) begin
          rq.x = CoordW'($urandom);
          rq.y = CoordW'($urandom);
        end else if (mode == 1) begin
          rq.x = to_coord(jitter(span));
          rq.y = to_coord(jitter(span));
        end else if (mode == 2) begin
          a    = $urandom_range(0, nv - 1);
          b    = (a + 1 == nv) ? 0 : a + 1;
          t    = $urandom_range(0, 256);
          rq.x = to_coord(room_x[a] + (longint'(room_x[b]) - room_x[a]) * t / 256
                          + jitter(reach));
          rq.y = to_coord(room_y[a] + (longint'(room_y[b]) - room_y[a]) * t / 256
                          + jitter(reach));
        end else begin
          a    = $urandom_range(0, nv - 1);
          rq.x = to_coord(room_x[a] + jitter(reach));
          rq.y = to_coord(room_y[a] + jitter(reach));
        end
        push_req(rq, Derived);
      end
      phase++;
    end

    // Wind down: nothing more offered, every awaited point back, then a
    // quiet stretch in which any surplus result would still be caught.
    req_if.valid <= 1'b0;
    while (awaited_points.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: checks each accepted transaction against the oldest awaited
  // point and throttles ready. Once, early in the random part, it holds off
  // for a long stretch so the block backs up and stalls its request side.
  initial begin : result_monitor
    int              hold;
    filtered_point_t want;
    hold = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        points_seen++;
        if (awaited_points.size() == 0) begin
          flag_mismatch($sformatf("unexpected result x=%0d y=%0d keep=%0b",
                                  rsp_if.point_x, rsp_if.point_y, rsp_if.keep));
        end else begin
          want = awaited_points.pop_front();
          if (rsp_if.point_x !== want.x)
            flag_mismatch($sformatf("point_x %0d, wanted %0d", rsp_if.point_x, want.x));
          if (rsp_if.point_y !== want.y)
            flag_mismatch($sformatf("point_y %0d, wanted %0d", rsp_if.point_y, want.y));
          if (rsp_if.keep !== want.keep)
            flag_mismatch($sformatf("keep %0b, wanted %0b for point (%0d,%0d)",
                                    rsp_if.keep, want.keep, want.x, want.y));
        end
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!backlog_done && points_seen >= 30) begin
          backlog_done = 1'b1;
          hold = BacklogHold;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          hold = $urandom_range(1, 9);
        end
      end
    end
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin : watchdog
    #1600000;
    $display("simulation failed");
    $finish;
  end

endmodule
